@@ rtl/core/sre_pkg.sv @@
package sre_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PROB_W   = 16;
  localparam int unsigned EXP_W    = 16;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned PROD_W   = 25;
  localparam int unsigned DIV_STEPS = 16;
  localparam logic [8:0]  EXP_SCALE = 9'd369;  // log2(e) in q.8

  typedef logic [EXP_W-1:0] exp_tbl_t [256];

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SUM_RD,
    ST_SUM_MUL,
    ST_SUM_EXP,
    ST_SUM_ACC,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_EXP,
    ST_EMIT_DIVI,
    ST_EMIT_DIV,
    ST_EMIT_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic expo;
    logic acc;
    logic sum_clr;
    logic div_init;
    logic div_step;
    logic push;
    logic idx_clr;
    logic idx_inc;
    logic row_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } dp_status_t;

  // 2^(-j/256) scaled by 65535, taylor series of exp in q63, rounded half up
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    tbl;
    logic [63:0]  stp;
    logic [63:0]  x;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [63:0]  prod;
    logic [127:0] wide;
    stp = 64'hB17217F7D1CF79AC >> 9;
    for (int j = 0; j < 256; j++) begin
      x    = stp * 64'(j);
      term = 64'h8000000000000000;
      acc  = 64'h8000000000000000;
      for (int k = 1; k <= 28; k++) begin
        wide = {64'd0, term} * {64'd0, x};
        term = wide[126:63] / 64'(k);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      prod = (acc >> 16) * 64'd65535;
      prod = (prod + (64'd1 << 46)) >> 47;
      if (prod > 64'd65535) begin
        prod = 64'd65535;
      end
      tbl[j] = prod[15:0];
    end
    return tbl;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

@@ rtl/core/softmax_row_engine_unit.sv @@
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// input     | in_valid, in_ready, in_sample, in_row_end      | in
// result    | out_valid, out_ready, out_probability,         | out
//           | out_last_of_row, out_row_truncated             |
//
// a sample is taken in one cycle; a mid-row sample yields no result
// at row end: a sum pass over the row (read, multiply, exp lookup, accumulate),
// then an emit pass per element (read, multiply, exp lookup, divider init,
// 16-step serial restoring divider, push to the output register)
// rst_n is synchronous; the row store needs no clearing after reset
// a stalled result holds in the output register; after a row's last result, a new row loads meanwhile
module softmax_row_engine_unit #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sre_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_row_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sre_pkg::PROB_W-1:0]           out_probability,
  output logic                                 out_last_of_row,
  output logic                                 out_row_truncated
);

  // command and status between controller and datapath
  sre_pkg::dp_cmd_t    cmd;
  sre_pkg::dp_status_t status;

  // sequencer: load, sum pass, emit pass
  sre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_row_end (in_row_end),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // row store, max tracking, exp, sum, divider and output register
  sre_dp #(
    .ROW_MAX (ROW_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_sample         (in_sample),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_probability   (out_probability),
    .out_last_of_row   (out_last_of_row),
    .out_row_truncated (out_row_truncated)
  );

endmodule

@@ rtl/core/sre_ram.sv @@
module sre_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sre_ctrl.sv @@
module sre_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_row_end,
  output logic                 in_ready,
  input  sre_pkg::dp_status_t  status,
  output sre_pkg::dp_cmd_t     cmd
);

  sre_pkg::state_t state_r, state_nxt;
  logic [3:0]      div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sre_pkg::ST_LOAD;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      sre_pkg::ST_LOAD: begin
        if (in_valid && in_row_end) state_nxt = sre_pkg::ST_SUM_RD;
      end
      sre_pkg::ST_SUM_RD:  state_nxt = sre_pkg::ST_SUM_MUL;
      sre_pkg::ST_SUM_MUL: state_nxt = sre_pkg::ST_SUM_EXP;
      sre_pkg::ST_SUM_EXP: state_nxt = sre_pkg::ST_SUM_ACC;
      sre_pkg::ST_SUM_ACC: begin
        state_nxt = status.idx_last ? sre_pkg::ST_EMIT_RD : sre_pkg::ST_SUM_RD;
      end
      sre_pkg::ST_EMIT_RD:  state_nxt = sre_pkg::ST_EMIT_MUL;
      sre_pkg::ST_EMIT_MUL: state_nxt = sre_pkg::ST_EMIT_EXP;
      sre_pkg::ST_EMIT_EXP: state_nxt = sre_pkg::ST_EMIT_DIVI;
      sre_pkg::ST_EMIT_DIVI: begin
        state_nxt   = sre_pkg::ST_EMIT_DIV;
        div_cnt_nxt = '0;
      end
      sre_pkg::ST_EMIT_DIV: begin
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(sre_pkg::DIV_STEPS - 1)) state_nxt = sre_pkg::ST_EMIT_PUSH;
      end
      sre_pkg::ST_EMIT_PUSH: begin
        if (status.out_free) begin
          state_nxt = status.idx_last ? sre_pkg::ST_LOAD : sre_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = sre_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sre_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_row_end) begin
            cmd.idx_clr = 1'b1;
            cmd.sum_clr = 1'b1;
          end
        end
      end
      sre_pkg::ST_SUM_RD, sre_pkg::ST_EMIT_RD:   cmd.rd = 1'b1;
      sre_pkg::ST_SUM_MUL, sre_pkg::ST_EMIT_MUL: cmd.mul = 1'b1;
      sre_pkg::ST_SUM_EXP, sre_pkg::ST_EMIT_EXP: cmd.expo = 1'b1;
      sre_pkg::ST_SUM_ACC: begin
        cmd.acc = 1'b1;
        if (status.idx_last) cmd.idx_clr = 1'b1;
        else                 cmd.idx_inc = 1'b1;
      end
      sre_pkg::ST_EMIT_DIVI: cmd.div_init = 1'b1;
      sre_pkg::ST_EMIT_DIV:  cmd.div_step = 1'b1;
      sre_pkg::ST_EMIT_PUSH: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          if (status.idx_last) cmd.row_clr = 1'b1;
          else                 cmd.idx_inc = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/sre_dp.sv @@
module sre_dp #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sre_pkg::dp_cmd_t                     cmd,
  output sre_pkg::dp_status_t                  status,
  input  logic signed [sre_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [sre_pkg::PROB_W-1:0]           out_probability,
  output logic                                 out_last_of_row,
  output logic                                 out_row_truncated
);

  localparam int unsigned CNT_W  = $clog2(ROW_MAX + 1);
  localparam int unsigned ADDR_W = $clog2(ROW_MAX);

  logic [CNT_W-1:0]                    count_r;
  logic [ADDR_W-1:0]                   idx_r;
  logic signed [sre_pkg::SAMPLE_W-1:0] max_r;
  logic                                ovf_r;
  logic [sre_pkg::PROD_W-1:0]          prod_r;
  logic [sre_pkg::EXP_W-1:0]           e_r;
  logic [sre_pkg::SUM_W-1:0]           sum_r;
  logic [sre_pkg::SUM_W-1:0]           rem_r;
  logic [sre_pkg::PROB_W-1:0]          quo_r;
  logic                                out_valid_r;
  logic [sre_pkg::PROB_W-1:0]          prob_r;
  logic                                last_r;
  logic                                trunc_r;

  logic                                full;
  logic                                wr_en;
  logic [sre_pkg::SAMPLE_W-1:0]        rd_data;
  logic [sre_pkg::SAMPLE_W-1:0]        diff;
  logic [16:0]                         u;
  logic [sre_pkg::EXP_W-1:0]           e_val;
  logic [31:0]                         num;
  logic [sre_pkg::SUM_W:0]             trial;
  logic                                fits;

  assign full  = (count_r == CNT_W'(ROW_MAX));
  assign wr_en = cmd.load && !full;

  sre_ram #(
    .WIDTH (sre_pkg::SAMPLE_W),
    .DEPTH (ROW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_sample),
    .re    (cmd.rd),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // max minus sample is never negative
  assign diff = sre_pkg::SAMPLE_W'(max_r - $signed(rd_data));
  assign u    = prod_r[sre_pkg::PROD_W-1:8];
  assign e_val = (u[16:8] >= 9'd16) ? '0 : (sre_pkg::EXP_TBL[u[7:0]] >> u[11:8]);

  assign num   = {e_r, 16'd0} - {16'd0, e_r};
  assign trial = {rem_r, quo_r[sre_pkg::PROB_W-1]};
  assign fits  = (trial >= {1'b0, sum_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      max_r       <= {1'b1, {(sre_pkg::SAMPLE_W-1){1'b0}}};
      ovf_r       <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
          if (in_sample > max_r) max_r <= in_sample;
        end
      end
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + ADDR_W'(1);
      if (cmd.sum_clr)      sum_r <= '0;
      else if (cmd.acc)     sum_r <= sum_r + sre_pkg::SUM_W'(e_r);
      if (cmd.row_clr) begin
        count_r <= '0;
        idx_r   <= '0;
        max_r   <= {1'b1, {(sre_pkg::SAMPLE_W-1){1'b0}}};
        ovf_r   <= 1'b0;
      end
      if (cmd.push)                      out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul)  prod_r <= {9'd0, diff} * {16'd0, sre_pkg::EXP_SCALE};
    if (cmd.expo) e_r    <= e_val;
    if (cmd.div_init) begin
      rem_r <= sre_pkg::SUM_W'(num[31:16]);
      quo_r <= num[15:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? sre_pkg::SUM_W'(trial - {1'b0, sum_r}) : trial[sre_pkg::SUM_W-1:0];
      quo_r <= {quo_r[sre_pkg::PROB_W-2:0], fits};
    end
    if (cmd.push) begin
      prob_r  <= quo_r;
      last_r  <= status.idx_last;
      trunc_r <= ovf_r;
    end
  end

  assign status.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_probability   = prob_r;
  assign out_last_of_row   = last_r;
  assign out_row_truncated = trunc_r;

endmodule

@@ rtl/core/sre_checker.sv @@
module sre_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [sre_pkg::SAMPLE_W-1:0] in_sample,
  input logic                                in_row_end,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [sre_pkg::PROB_W-1:0]          out_probability,
  input logic                                out_last_of_row,
  input logic                                out_row_truncated
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability)
      && $stable(out_last_of_row) && $stable(out_row_truncated))
    else $error("result changed while stalled");

  // row end starts the sum pass, no further samples taken
  a_row_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_end |=> !in_ready)
    else $error("sample taken right after row end");

  // mid-row sample never launches a result
  a_mid_row_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_row_end |=> !$rose(out_valid))
    else $error("result after mid-row sample");

endmodule

bind softmax_row_engine_unit sre_checker u_sre_checker (.*);

@@ sim/softmax_row_engine_unit_tb.sv @@
`timescale 1ns / 1ps

module softmax_row_engine_unit_tb;

  localparam int unsigned ROW_MAX = 64;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [sre_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_row_end;
  logic                                out_valid;
  logic                                out_ready;
  logic [sre_pkg::PROB_W-1:0]          out_probability;
  logic                                out_last_of_row;
  logic                                out_row_truncated;

  softmax_row_engine_unit #(
    .ROW_MAX(ROW_MAX)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_row_end       (in_row_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_probability  (out_probability),
    .out_last_of_row  (out_last_of_row),
    .out_row_truncated(out_row_truncated)
  );

  // one expected softmax result
  typedef struct packed {
    logic [sre_pkg::PROB_W-1:0] prob;
    logic                       last;
    logic                       trunc;
  } prob_item_t;

  // predictor state, mirrors the block's row store
  logic [15:0]        pow2_lut [256];
  logic signed [15:0] row_buf [ROW_MAX];
  logic signed [15:0] peak;
  int unsigned        n_stored;
  bit                 dropped;
  prob_item_t         prob_queue [$];

  int  errors;
  bit  quiet;        // no idling in the last part of the run
  bit  long_hold;    // receiver holds off
  int  stall_left;

  // 2^(-j/256) * 65535, q63 taylor series of exp(-x), rounded half up
  task automatic build_pow2_lut();
    logic [63:0]  stp;
    logic [63:0]  x;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [63:0]  prod;
    logic [127:0] wide;
    stp = 64'hB17217F7D1CF79AC >> 9;
    for (int j = 0; j < 256; j++) begin
      x    = stp * 64'(j);
      term = 64'h8000000000000000;
      acc  = 64'h8000000000000000;
      for (int k = 1; k <= 28; k++) begin
        wide = 128'(term) * 128'(x);
        term = wide[126:63] / 64'(k);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      prod = (acc >> 16) * 64'd65535;
      prod = (prod + (64'd1 << 46)) >> 47;
      if (prod > 64'd65535) begin
        prod = 64'd65535;
      end
      pow2_lut[j] = prod[15:0];
    end
  endtask

  // exp(-(peak - x)/256) scaled by 65535, computed as a base-2 exponential
  function automatic logic [31:0] exp_weight(logic signed [15:0] x);
    logic [31:0] d;
    logic [31:0] u;
    d = 32'(32'(signed'(peak)) - 32'(signed'(x))) & 32'hFFFF;
    u = (d * 32'd369) >> 8;
    if ((u >> 8) >= 16) begin
      return 32'd0;
    end
    return 32'(pow2_lut[u[7:0]]) >> (u >> 8);
  endfunction

  // accepted sample: store it, and at row end queue the probabilities
  task automatic predict_softmax(logic signed [15:0] x, logic row_end);
    logic [31:0] sum;
    logic [31:0] e;
    prob_item_t  r;
    if (n_stored < ROW_MAX) begin
      row_buf[n_stored] = x;
      n_stored++;
      if (x > peak) begin
        peak = x;
      end
    end else begin
      dropped = 1'b1;
    end
    if (!row_end) begin
      return;
    end
    sum = 0;
    for (int i = 0; i < n_stored; i++) begin
      sum += exp_weight(row_buf[i]);
    end
    sum &= 32'h3FFFFF;
    for (int i = 0; i < n_stored; i++) begin
      e       = exp_weight(row_buf[i]);
      r.prob  = (sum != 0) ? 16'((e * 32'd65535) / sum) : 16'd0;
      r.last  = (i + 1 == n_stored);
      r.trunc = dropped;
      prob_queue.push_back(r);
    end
    peak     = -16'sd32768;
    n_stored = 0;
    dropped  = 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #400ms;
    $display("FAILURE");
    $finish;
  end

  // drive one transaction, sometimes with a random leading gap unless quiet
  task automatic send_sample(logic signed [15:0] x, logic row_end);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= x;
    in_row_end <= row_end;
    predict_softmax(x, row_end);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_row(int len, int lo, int hi);
    for (int i = 0; i < len; i++) begin
      send_sample(16'($urandom_range(hi - lo) + lo), i == len - 1);
    end
  endtask

  // receiver idling in random bursts, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    prob_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (prob_queue.size() == 0) begin
        $display("%0t: unexpected transaction prob=%0d", $time, out_probability);
        errors++;
      end else begin
        want = prob_queue.pop_front();
        if (out_probability !== want.prob) begin
          $display("%0t: probability expected %0d actual %0d",
                   $time, want.prob, out_probability);
          errors++;
        end
        if (out_last_of_row !== want.last) begin
          $display("%0t: last_of_row expected %0b actual %0b",
                   $time, want.last, out_last_of_row);
          errors++;
        end
        if (out_row_truncated !== want.trunc) begin
          $display("%0t: row_truncated expected %0b actual %0b",
                   $time, want.trunc, out_row_truncated);
          errors++;
        end
      end
    end
  end

  // field extremes, single element rows, equal and wide spreads
  task automatic test_directed();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd256, 1'b0);
    send_sample(-16'sd256, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(-16'sh5556, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd99, 1'b1);
  endtask

  // rows of full store and past it, row_end sample dropped
  task automatic test_overflow();
    send_row(ROW_MAX, -2000, 2000);
    send_row(ROW_MAX + 3, -32768, 32767);
    send_row(ROW_MAX + 1, 0, 512);
  endtask

  // receiver blocked while rows keep coming
  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        for (int r = 0; r < 4; r++) begin
          send_row($urandom_range(2, 8), -1024, 1024);
        end
      end
    join
  endtask

  // random rows, mostly short, close spreads and full range
  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, ROW_MAX + 2)
                                        : $urandom_range(1, 8);
      if ($urandom_range(0, 1)) begin
        send_row(len, -32768, 32767);
      end else begin
        send_row(len, -1500, 1500);
      end
      sent += len;
    end
  endtask

  initial begin
    int guard;
    errors     = 0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    peak       = -16'sd32768;
    n_stored   = 0;
    dropped    = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    in_row_end = 1'b0;
    build_pow2_lut();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_backpressure();
    test_random(130);
    quiet = 1'b1;
    test_random(60);
    in_valid <= 1'b0;

    // drain, then allow for the emit pass latency
    guard = 0;
    while (prob_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && prob_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
